/* rtl/dead_zone_camera_follow_top_macros.svh */
// ----------------------------------------------------------------------------
// Dead-zone camera follow: assertion macros
// Immediate-consequence and next-cycle property checks with a common report.
// ----------------------------------------------------------------------------
`ifndef DEAD_ZONE_CAMERA_FOLLOW_TOP_MACROS_SVH
`define DEAD_ZONE_CAMERA_FOLLOW_TOP_MACROS_SVH

// Check cons in the same cycle as ante.
`define DZCF_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dzcf: same-cycle check failed");

// Check cons in the cycle after ante.
`define DZCF_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dzcf: next-cycle check failed");

`endif

/* rtl/dzcf_pkg.sv */
// ----------------------------------------------------------------------------
// Dead-zone camera follow package
// Fixed field widths, register map, sequencer states and divider links.
// ----------------------------------------------------------------------------
`default_nettype none

package dzcf_pkg;

  localparam int unsigned VIEW_BITS  = 31;
  localparam int unsigned ZFRAC_BITS = 17;
  localparam int unsigned PROD_BITS  = VIEW_BITS + ZFRAC_BITS;
  localparam int unsigned ZONE_BITS  = 31;
  localparam int unsigned RATIO_BITS = 32;
  localparam int unsigned ZONE_SHIFT = 16;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned DIV_CNT_W  = $clog2(RATIO_BITS);

  localparam logic [VIEW_BITS-1:0]  VIEW_WIDTH_RST  = 31'd1310720;
  localparam logic [VIEW_BITS-1:0]  VIEW_HEIGHT_RST = 31'd983040;
  localparam logic [ZFRAC_BITS-1:0] ZONE_FRAC_RST   = 17'd32768;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_VIEW_WIDTH  = 4'd0,
    REG_VIEW_HEIGHT = 4'd1,
    REG_ZONE_FRAC_X = 4'd2,
    REG_ZONE_FRAC_Y = 4'd3,
    REG_BOUND_MIN_X = 4'd4,
    REG_BOUND_MAX_X = 4'd5,
    REG_BOUND_MIN_Y = 4'd6,
    REG_BOUND_MAX_Y = 4'd7
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_FOLLOW,
    ST_LIMIT,
    ST_CLAMP,
    ST_DIV
  } dzcf_state_e;

  typedef struct packed {
    logic                  start;
    logic [VIEW_BITS-1:0]  divisor;
    logic [VIEW_BITS-1:0]  rem;
    logic [RATIO_BITS-1:0] num;
  } div_ctrl_t;

  typedef struct packed {
    logic busy;
  } div_stat_t;

endpackage

`default_nettype wire

/* rtl/dzcf_in_if.sv */
// ----------------------------------------------------------------------------
// Dead-zone camera follow: target channel
// Valid/ready channel carrying one tracked position per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface dzcf_in_if #(
  parameter int unsigned POS_BITS = 32
) ();
  logic                       valid;
  logic                       ready;
  logic signed [POS_BITS-1:0] target_x;
  logic signed [POS_BITS-1:0] target_y;

  modport source (output valid, output target_x, output target_y, input ready);
  modport sink   (input valid, input target_x, input target_y, output ready);
endinterface

`default_nettype wire

/* rtl/dzcf_out_if.sv */
// ----------------------------------------------------------------------------
// Dead-zone camera follow: result channel
// Valid/ready channel carrying the new centre, ratios and zone size per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface dzcf_out_if #(
  parameter int unsigned POS_BITS = 32
) ();
  logic                       valid;
  logic                       ready;
  logic signed [POS_BITS-1:0] center_x;
  logic signed [POS_BITS-1:0] center_y;
  logic [31:0]                ratio_x;
  logic [31:0]                ratio_y;
  logic [30:0]                zone_width;
  logic [30:0]                zone_height;

  modport source (
    output valid, output center_x, output center_y, output ratio_x,
    output ratio_y, output zone_width, output zone_height, input ready
  );
  modport sink (
    input valid, input center_x, input center_y, input ratio_x,
    input ratio_y, input zone_width, input zone_height, output ready
  );
endinterface

`default_nettype wire

/* rtl/dzcf_cfg_if.sv */
// ----------------------------------------------------------------------------
// Dead-zone camera follow: register write channel
// Valid/ready channel carrying a register index and write data per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface dzcf_cfg_if #(
  parameter int unsigned POS_BITS = 32
) ();
  localparam int unsigned DATA_BITS = (POS_BITS > 32) ? POS_BITS : 32;

  logic                 valid;
  logic                 ready;
  logic [3:0]           addr;
  logic [DATA_BITS-1:0] data;

  modport source (output valid, output addr, output data, input ready);
  modport sink   (input valid, input addr, input data, output ready);
endinterface

`default_nettype wire

/* rtl/dead_zone_camera_follow_top.sv */
// ----------------------------------------------------------------------------
// Dead-zone camera follow
// Camera centre tracking with a dead zone and world-bound clamping.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : one tracked position (target_x, target_y) per beat.
//   out_o : one result per input beat: new centre, |offset| over half view
//           per axis (saturating), and the dead-zone size.
//   cfg_i : register writes (index, data), always ready; write only while
//           no item is in flight. Indexes beyond the register map are dropped.
// Each axis runs in turn through load, follow, limit and clamp steps while a
// shared restoring divider produces its ratio at one bit per cycle. The
// divider steps per axis set the pace: a result is registered once both axes
// are through, and a new input is taken in the next cycle, so only one item
// is in flight at a time.
// The result register parts the two sides: a finished result waits there
// while the next input is accepted; if the receiver still stalls when the
// next result is ready, the sequencer holds until the register frees.
// Reset restores the register defaults, puts the camera at the origin and
// empties the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dead_zone_camera_follow_top #(
  parameter int unsigned POS_BITS  = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  wire    clk_i,
  input  wire    rst_ni,
  dzcf_cfg_if.sink   cfg_i,
  dzcf_in_if.sink    in_i,
  dzcf_out_if.source out_o
);
  import dzcf_pkg::*;

  localparam int unsigned EW = ((POS_BITS > 32) ? POS_BITS : 32) + 3;
  localparam int unsigned DW = POS_BITS + 1;
  localparam int unsigned AW = POS_BITS + 2;
  localparam int unsigned LW = ((AW > (VIEW_BITS + RATIO_BITS - FRAC_BITS)) ? AW :
                                (VIEW_BITS + RATIO_BITS - FRAC_BITS));
  localparam int unsigned NW = POS_BITS + FRAC_BITS + 40;

  localparam logic signed [POS_BITS-1:0] POS_MAX_P = {1'b0, {(POS_BITS-1){1'b1}}};
  localparam logic signed [POS_BITS-1:0] POS_MIN_P = {1'b1, {(POS_BITS-1){1'b0}}};
  localparam logic signed [EW-1:0]       E_MAX     = EW'(POS_MAX_P);
  localparam logic signed [EW-1:0]       E_MIN     = EW'(POS_MIN_P);

  function automatic logic signed [POS_BITS-1:0] sat_pos(input logic signed [EW-1:0] v);
    logic signed [POS_BITS-1:0] r;
    if (v > E_MAX) begin
      r = POS_MAX_P;
    end else if (v < E_MIN) begin
      r = POS_MIN_P;
    end else begin
      r = v[POS_BITS-1:0];
    end
    return r;
  endfunction

  // configuration
  logic [VIEW_BITS-1:0]       view_w_q, view_h_q;
  logic [ZFRAC_BITS-1:0]      frac_x_q, frac_y_q;
  logic signed [POS_BITS-1:0] bmin_x_q, bmax_x_q, bmin_y_q, bmax_y_q;

  // sequencer and datapath
  dzcf_state_e                state_q, state_d;
  logic                       axis_q, axis_d;
  logic                       ld_in, ld_prod, ld_follow, ld_limit, ld_clamp, ld_rx, ld_out;
  logic signed [POS_BITS-1:0] tx_q, ty_q;
  logic signed [POS_BITS-1:0] cam_x_q, cam_y_q;
  logic [PROD_BITS-1:0]       prod_q;
  logic signed [DW-1:0]       d_q;
  logic signed [POS_BITS-1:0] nc_q;
  logic                       sat_q;
  logic [ZONE_BITS-1:0]       zone_x_q, zone_y_q;
  logic [RATIO_BITS-1:0]      ratio_x_q;
  logic signed [POS_BITS-1:0] lo_q, hi_q, mid_q;
  logic                       narrow_q, has_min_q, has_max_q;
  logic                       out_valid_q;
  logic signed [POS_BITS-1:0] oc_x_q, oc_y_q;
  logic [RATIO_BITS-1:0]      or_x_q, or_y_q;
  logic [ZONE_BITS-1:0]       oz_w_q, oz_h_q;

  // axis operands
  logic signed [POS_BITS-1:0] tgt, cam, bmin, bmax;
  logic [VIEW_BITS-1:0]       view;
  logic [ZFRAC_BITS-1:0]      frac;

  // follow step
  logic [VIEW_BITS-1:0]       hz;
  logic signed [EW-1:0]       hz_e, d_e, t_e;
  logic signed [POS_BITS-1:0] nc_f;
  logic [ZONE_BITS:0]         zone_full;
  logic [ZONE_BITS-1:0]       zone_val;
  logic [DW-1:0]              mag;
  logic [AW-1:0]              ad2;
  logic [LW-1:0]              ad2_l, lim_l;
  logic [NW-1:0]              n_full;
  logic                       sat_f;

  // limit and clamp steps
  logic signed [EW-1:0]       bmin_e, bmax_e, half_e, view_e, sum_e;
  logic signed [POS_BITS-1:0] clamp_c;
  logic [RATIO_BITS-1:0]      ratio_f;

  div_ctrl_t             div_ctrl;
  div_stat_t             div_stat;
  logic [RATIO_BITS-1:0] div_quot;

  assign tgt  = axis_q ? ty_q     : tx_q;
  assign cam  = axis_q ? cam_y_q  : cam_x_q;
  assign bmin = axis_q ? bmin_y_q : bmin_x_q;
  assign bmax = axis_q ? bmax_y_q : bmax_x_q;
  assign view = axis_q ? view_h_q : view_w_q;
  assign frac = axis_q ? frac_y_q : frac_x_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      view_w_q <= VIEW_WIDTH_RST;
      view_h_q <= VIEW_HEIGHT_RST;
      frac_x_q <= ZONE_FRAC_RST;
      frac_y_q <= ZONE_FRAC_RST;
      bmin_x_q <= POS_MIN_P;
      bmax_x_q <= POS_MAX_P;
      bmin_y_q <= POS_MIN_P;
      bmax_y_q <= POS_MAX_P;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_i.addr)
        REG_VIEW_WIDTH:  view_w_q <= cfg_i.data[VIEW_BITS-1:0];
        REG_VIEW_HEIGHT: view_h_q <= cfg_i.data[VIEW_BITS-1:0];
        REG_ZONE_FRAC_X: frac_x_q <= cfg_i.data[ZFRAC_BITS-1:0];
        REG_ZONE_FRAC_Y: frac_y_q <= cfg_i.data[ZFRAC_BITS-1:0];
        REG_BOUND_MIN_X: bmin_x_q <= cfg_i.data[POS_BITS-1:0];
        REG_BOUND_MAX_X: bmax_x_q <= cfg_i.data[POS_BITS-1:0];
        REG_BOUND_MIN_Y: bmin_y_q <= cfg_i.data[POS_BITS-1:0];
        REG_BOUND_MAX_Y: bmax_y_q <= cfg_i.data[POS_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d   = state_q;
    axis_d    = axis_q;
    ld_in     = 1'b0;
    ld_prod   = 1'b0;
    ld_follow = 1'b0;
    ld_limit  = 1'b0;
    ld_clamp  = 1'b0;
    ld_rx     = 1'b0;
    ld_out    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_i.valid) begin
          ld_in   = 1'b1;
          axis_d  = 1'b0;
          state_d = ST_LOAD;
        end
      end
      ST_LOAD: begin
        ld_prod = 1'b1;
        state_d = ST_FOLLOW;
      end
      ST_FOLLOW: begin
        ld_follow = 1'b1;
        state_d   = ST_LIMIT;
      end
      ST_LIMIT: begin
        ld_limit = 1'b1;
        state_d  = ST_CLAMP;
      end
      ST_CLAMP: begin
        ld_clamp = 1'b1;
        state_d  = ST_DIV;
      end
      ST_DIV: begin
        if (!div_stat.busy) begin
          if (!axis_q) begin
            ld_rx   = 1'b1;
            axis_d  = 1'b1;
            state_d = ST_LOAD;
          end else if (!out_valid_q || out_o.ready) begin
            ld_out  = 1'b1;
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      axis_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      axis_q  <= axis_d;
    end
  end

  always_comb begin
    hz        = prod_q[PROD_BITS-1:ZONE_SHIFT+1];
    hz_e      = EW'(hz);
    d_e       = EW'(d_q);
    t_e       = EW'(tgt);
    if (d_e > hz_e) begin
      nc_f = sat_pos(t_e - hz_e);
    end else if (d_e < -hz_e) begin
      nc_f = sat_pos(t_e + hz_e);
    end else begin
      nc_f = cam;
    end
    zone_full = prod_q[PROD_BITS-1:ZONE_SHIFT];
    zone_val  = zone_full[ZONE_BITS] ? {ZONE_BITS{1'b1}} : zone_full[ZONE_BITS-1:0];
    mag       = d_q[DW-1] ? DW'(-d_q) : DW'(d_q);
    ad2       = AW'(mag) << 1;
    ad2_l     = LW'(ad2);
    lim_l     = LW'(view) << (RATIO_BITS - FRAC_BITS);
    sat_f     = (ad2_l >= lim_l);
    n_full    = NW'(ad2) << FRAC_BITS;
  end

  assign div_ctrl.start   = ld_follow;
  assign div_ctrl.divisor = view;
  assign div_ctrl.rem     = n_full[RATIO_BITS+VIEW_BITS-1:RATIO_BITS];
  assign div_ctrl.num     = n_full[RATIO_BITS-1:0];

  always_comb begin
    bmin_e = EW'(bmin);
    bmax_e = EW'(bmax);
    half_e = EW'(view >> 1);
    view_e = EW'(view);
    sum_e  = bmin_e + bmax_e;
  end

  always_comb begin
    if (has_min_q && has_max_q && narrow_q) begin
      clamp_c = mid_q;
    end else begin
      clamp_c = nc_q;
      if (has_min_q && (clamp_c < lo_q)) begin
        clamp_c = lo_q;
      end
      if (has_max_q && (clamp_c > hi_q)) begin
        clamp_c = hi_q;
      end
    end
  end

  assign ratio_f = sat_q ? {RATIO_BITS{1'b1}} : div_quot;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cam_x_q     <= '0;
      cam_y_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (ld_clamp) begin
        if (axis_q) begin
          cam_y_q <= clamp_c;
        end else begin
          cam_x_q <= clamp_c;
        end
      end
      if (ld_out) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_in) begin
      tx_q <= in_i.target_x;
      ty_q <= in_i.target_y;
    end
    if (ld_prod) begin
      prod_q <= PROD_BITS'(view) * PROD_BITS'(frac);
      d_q    <= DW'(tgt) - DW'(cam);
    end
    if (ld_follow) begin
      nc_q  <= nc_f;
      sat_q <= sat_f;
      if (axis_q) begin
        zone_y_q <= zone_val;
      end else begin
        zone_x_q <= zone_val;
      end
    end
    if (ld_limit) begin
      has_min_q <= (bmin != POS_MIN_P);
      has_max_q <= (bmax != POS_MAX_P);
      narrow_q  <= ((bmax_e - bmin_e) < view_e);
      mid_q     <= POS_BITS'(sum_e >>> 1);
      lo_q      <= sat_pos(bmin_e + half_e);
      hi_q      <= sat_pos(bmax_e - half_e);
    end
    if (ld_rx) begin
      ratio_x_q <= ratio_f;
    end
    if (ld_out) begin
      oc_x_q <= cam_x_q;
      oc_y_q <= cam_y_q;
      or_x_q <= ratio_x_q;
      or_y_q <= ratio_f;
      oz_w_q <= zone_x_q;
      oz_h_q <= zone_y_q;
    end
  end

  dzcf_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (div_ctrl),
    .stat_o (div_stat),
    .quot_o (div_quot)
  );

  assign in_i.ready        = (state_q == ST_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.center_x    = oc_x_q;
  assign out_o.center_y    = oc_y_q;
  assign out_o.ratio_x     = or_x_q;
  assign out_o.ratio_y     = or_y_q;
  assign out_o.zone_width  = oz_w_q;
  assign out_o.zone_height = oz_h_q;

endmodule

`default_nettype wire

/* rtl/dzcf_div.sv */
// ----------------------------------------------------------------------------
// Dead-zone camera follow: shared divider
// Restoring divider, one quotient bit per cycle, 32 bits per quotient.
// ----------------------------------------------------------------------------
`default_nettype none

module dzcf_div (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  dzcf_pkg::div_ctrl_t                ctrl_i,
  output dzcf_pkg::div_stat_t                stat_o,
  output logic [dzcf_pkg::RATIO_BITS-1:0]    quot_o
);
  import dzcf_pkg::*;

  logic                  busy_q, busy_d;
  logic [DIV_CNT_W-1:0]  cnt_q, cnt_d;
  logic [VIEW_BITS-1:0]  rem_q, rem_d;
  logic [VIEW_BITS-1:0]  dvsr_q, dvsr_d;
  logic [RATIO_BITS-1:0] num_q, num_d;
  logic [VIEW_BITS:0]    trial;
  logic [VIEW_BITS:0]    diff;
  logic                  ge;

  always_comb begin
    trial  = {rem_q, num_q[RATIO_BITS-1]};
    diff   = trial - {1'b0, dvsr_q};
    ge     = (trial >= {1'b0, dvsr_q});
    busy_d = busy_q;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    num_d  = num_q;
    dvsr_d = dvsr_q;
    if (ctrl_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = ctrl_i.rem;
      num_d  = ctrl_i.num;
      dvsr_d = ctrl_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? diff[VIEW_BITS-1:0] : trial[VIEW_BITS-1:0];
      num_d = {num_q[RATIO_BITS-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DIV_CNT_W'(RATIO_BITS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    num_q  <= num_d;
    dvsr_q <= dvsr_d;
  end

  assign stat_o.busy = busy_q;
  assign quot_o      = num_q;

endmodule

`default_nettype wire

/* rtl/dzcf_checker.sv */
// ----------------------------------------------------------------------------
// Dead-zone camera follow: port checker
// Watches the top-level channels over time; bound onto the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "dead_zone_camera_follow_top_macros.svh"

module dzcf_checker #(
  parameter int unsigned POS_BITS = 32
) (
  input wire                clk_i,
  input wire                rst_ni,
  input wire                in_valid_i,
  input wire                in_ready_i,
  input wire                out_valid_i,
  input wire                out_ready_i,
  input wire [POS_BITS-1:0] center_x_i,
  input wire [31:0]         ratio_x_i
);

  // hold a stalled result beat
  `DZCF_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `DZCF_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(center_x_i) && $stable(ratio_x_i))
  // one item in flight: input closes after each accepted beat
  `DZCF_ASSERT_NXT(a_in_close, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)
  // a new result only appears at the end of a busy period
  `DZCF_ASSERT_IMP(a_out_after_work, clk_i, rst_ni, $rose(out_valid_i), $past(!in_ready_i))

endmodule

bind dead_zone_camera_follow_top dzcf_checker #(
  .POS_BITS (POS_BITS)
) u_dzcf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .center_x_i  (out_o.center_x),
  .ratio_x_i   (out_o.ratio_x)
);

`default_nettype wire

/* sim/dead_zone_camera_follow_top_tb.sv */
// ----------------------------------------------------------------------------
// Dead-zone camera follow: testbench
// Drives target beats and register writes into the camera follow block and
// checks every result beat against an in-bench model of the dead zone, the
// world-bound clamp, the offset ratio and the zone size. A short table of
// directed rows comes first, then random phases under several register
// settings and idling mixes, one of them with a long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module dead_zone_camera_follow_top_tb;
  import dzcf_pkg::*;

  localparam int unsigned POS_BITS      = 32;
  localparam int unsigned FRAC_BITS     = 16;
  localparam int          N_PHASES      = 8;
  localparam int          PHASE_ITEMS   = 205;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          DRAIN_CYCLES  = 100;
  localparam int          QUIET_LIMIT   = 5000;
  localparam logic [3:0]  IDX_UNUSED_LO = 4'd8;
  localparam logic [3:0]  IDX_UNUSED_HI = 4'd15;
  localparam longint      POS_MAX       = 64'sd2147483647;
  localparam longint      POS_MIN       = -64'sd2147483648;
  localparam longint      ZONE_MAX      = 64'sd2147483647;

  typedef struct packed {
    logic [31:0] center_x;
    logic [31:0] center_y;
    logic [31:0] ratio_x;
    logic [31:0] ratio_y;
    logic [30:0] zone_width;
    logic [30:0] zone_height;
  } frame_res_t;

  typedef struct packed {
    logic        is_cfg;
    logic [3:0]  idx;
    logic [31:0] a;
    logic [31:0] b;
    logic        typed;
    frame_res_t  res;
  } dir_row_t;

  typedef struct {
    longint view;
    longint frac;
    longint bmin;
    longint bmax;
  } axis_cfg_t;

  localparam frame_res_t NO_RES = '0;
  localparam int N_DIR = 25;
  localparam dir_row_t DIR_TAB [0:N_DIR-1] = '{
    '{1'b0, 4'd0, 32'h0000_0000, 32'h0000_0000, 1'b1,
      '{32'h0, 32'h0, 32'h0, 32'h0, 31'd655360, 31'd491520}},
    '{1'b0, 4'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, NO_RES},
    '{1'b0, 4'd0, 32'h0000_1000, 32'hFFFF_F000, 1'b0, NO_RES},
    '{1'b1, REG_VIEW_WIDTH,  32'h0000_0000, 32'h0, 1'b0, NO_RES},
    '{1'b1, REG_VIEW_HEIGHT, 32'h8000_0000, 32'h0, 1'b0, NO_RES},
    '{1'b0, 4'd0, 32'h1234_5678, 32'h8000_0000, 1'b1,
      '{32'h1234_5678, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'd0, 31'd0}},
    '{1'b1, IDX_UNUSED_LO, 32'h0001_0000, 32'h0, 1'b0, NO_RES},
    '{1'b1, IDX_UNUSED_HI, 32'h0001_0000, 32'h0, 1'b0, NO_RES},
    '{1'b0, 4'd0, 32'hFFFF_FFFB, 32'h0000_0007, 1'b1,
      '{32'hFFFF_FFFB, 32'h0000_0007, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'd0, 31'd0}},
    '{1'b1, REG_VIEW_WIDTH,  32'h7FFF_FFFF, 32'h0, 1'b0, NO_RES},
    '{1'b1, REG_VIEW_HEIGHT, 32'h0014_0000, 32'h0, 1'b0, NO_RES},
    '{1'b1, REG_ZONE_FRAC_X, 32'h0001_FFFF, 32'h0, 1'b0, NO_RES},
    '{1'b1, REG_ZONE_FRAC_Y, 32'h0000_0000, 32'h0, 1'b0, NO_RES},
    '{1'b0, 4'd0, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, NO_RES},
    '{1'b1, REG_ZONE_FRAC_X, 32'h0001_0000, 32'h0, 1'b0, NO_RES},
    '{1'b1, REG_BOUND_MIN_X, 32'h0002_0000, 32'h0, 1'b0, NO_RES},
    '{1'b1, REG_BOUND_MAX_X, 32'h0004_0000, 32'h0, 1'b0, NO_RES},
    '{1'b1, REG_BOUND_MIN_Y, 32'hFFF0_0000, 32'h0, 1'b0, NO_RES},
    '{1'b1, REG_BOUND_MAX_Y, 32'h0010_0000, 32'h0, 1'b0, NO_RES},
    '{1'b0, 4'd0, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0, NO_RES},
    '{1'b0, 4'd0, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, NO_RES},
    '{1'b1, REG_BOUND_MIN_X, 32'h0010_0000, 32'h0, 1'b0, NO_RES},
    '{1'b1, REG_BOUND_MAX_X, 32'hFFF0_0000, 32'h0, 1'b0, NO_RES},
    '{1'b0, 4'd0, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, NO_RES},
    '{1'b0, 4'd0, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, NO_RES}
  };

  logic clk;
  logic rst_n;

  dzcf_cfg_if #(.POS_BITS(POS_BITS)) cfg_if ();
  dzcf_in_if  #(.POS_BITS(POS_BITS)) in_if ();
  dzcf_out_if #(.POS_BITS(POS_BITS)) out_if ();

  dead_zone_camera_follow_top #(
    .POS_BITS (POS_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .cfg_i (cfg_if),
    .in_i  (in_if),
    .out_o (out_if)
  );

  frame_res_t pending_frames [$];
  axis_cfg_t  axis_cfg [2];
  longint     cam_pos [2];
  int         errors;
  int         n_targets;
  int         n_writes;
  int         n_checked;
  int         send_idle_pct;
  int         stall_pct;
  bit         hold_req;

  initial begin
    clk = 1'b0;
  end

  always #5 clk = ~clk;

  function automatic longint clamp_pos(longint v);
    if (v > POS_MAX) return POS_MAX;
    if (v < POS_MIN) return POS_MIN;
    return v;
  endfunction

  function automatic void apply_reg(logic [3:0] idx, logic [31:0] data);
    case (idx)
      REG_VIEW_WIDTH:  axis_cfg[0].view = longint'(data[30:0]);
      REG_VIEW_HEIGHT: axis_cfg[1].view = longint'(data[30:0]);
      REG_ZONE_FRAC_X: axis_cfg[0].frac = longint'(data[16:0]);
      REG_ZONE_FRAC_Y: axis_cfg[1].frac = longint'(data[16:0]);
      REG_BOUND_MIN_X: axis_cfg[0].bmin = longint'($signed(data));
      REG_BOUND_MAX_X: axis_cfg[0].bmax = longint'($signed(data));
      REG_BOUND_MIN_Y: axis_cfg[1].bmin = longint'($signed(data));
      REG_BOUND_MAX_Y: axis_cfg[1].bmax = longint'($signed(data));
      default: ;
    endcase
  endfunction

  function automatic void follow_axis(input longint tgt, input int ax,
                                      output logic [31:0] ratio,
                                      output logic [30:0] zone);
    longint d, ad2, prod, hz, half, nc, lo, hi, zw;
    bit     has_min, has_max;
    d       = tgt - cam_pos[ax];
    ad2     = 2 * ((d < 0) ? -d : d);
    prod    = axis_cfg[ax].view * axis_cfg[ax].frac;
    hz      = prod >>> (ZONE_SHIFT + 1);
    half    = axis_cfg[ax].view >>> 1;
    nc      = cam_pos[ax];
    has_min = axis_cfg[ax].bmin != POS_MIN;
    has_max = axis_cfg[ax].bmax != POS_MAX;
    if (ad2 >= (axis_cfg[ax].view <<< (32 - FRAC_BITS))) ratio = 32'hFFFF_FFFF;
    else ratio = 32'((ad2 <<< FRAC_BITS) / axis_cfg[ax].view);
    zw   = prod >>> ZONE_SHIFT;
    zone = (zw > ZONE_MAX) ? 31'h7FFF_FFFF : 31'(zw);
    if (d > hz) nc = clamp_pos(tgt - hz);
    else if (d < -hz) nc = clamp_pos(tgt + hz);
    if (has_min && has_max && (axis_cfg[ax].bmax - axis_cfg[ax].bmin) < axis_cfg[ax].view) begin
      nc = (axis_cfg[ax].bmin + axis_cfg[ax].bmax) >>> 1;
    end else begin
      if (has_min) begin
        lo = clamp_pos(axis_cfg[ax].bmin + half);
        if (nc < lo) nc = lo;
      end
      if (has_max) begin
        hi = clamp_pos(axis_cfg[ax].bmax - half);
        if (nc > hi) nc = hi;
      end
    end
    cam_pos[ax] = nc;
  endfunction

  function automatic frame_res_t next_frame(logic [31:0] tx, logic [31:0] ty);
    frame_res_t       f;
    logic signed [31:0] sx, sy;
    sx = tx;
    sy = ty;
    follow_axis(longint'(sx), 0, f.ratio_x, f.zone_width);
    follow_axis(longint'(sy), 1, f.ratio_y, f.zone_height);
    f.center_x = 32'(cam_pos[0]);
    f.center_y = 32'(cam_pos[1]);
    return f;
  endfunction

  function automatic logic [31:0] pick_coord(int ax);
    longint span, off, v;
    int     r;
    r    = $urandom_range(19);
    span = (axis_cfg[ax].view == 0) ? 64'sd1048576 : axis_cfg[ax].view;
    if ($urandom_range(1) == 1) span = (span >>> 2) + 1;
    off  = (longint'($urandom) % (2 * span + 1)) - span;
    if (r < 12) v = cam_pos[ax] + off;
    else if (r < 15) v = (($urandom_range(1) == 1) ? axis_cfg[ax].bmin : axis_cfg[ax].bmax) + off;
    else if (r < 18) v = longint'($signed($urandom));
    else begin
      case ($urandom_range(3))
        0:       v = POS_MIN;
        1:       v = POS_MAX;
        2:       v = 0;
        default: v = -1;
      endcase
    end
    return 32'(clamp_pos(v));
  endfunction

  task automatic write_reg(input logic [3:0] idx, input logic [31:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.addr  <= idx;
    cfg_if.data  <= data;
    do @(posedge clk); while (!cfg_if.ready);
    apply_reg(idx, data);
    n_writes++;
  endtask

  task automatic wait_idle();
    in_if.valid  <= 1'b0;
    cfg_if.valid <= 1'b0;
    do @(posedge clk); while (pending_frames.size() != 0);
  endtask

  task automatic send_target(input logic [31:0] tx, input logic [31:0] ty,
                             input logic typed, input frame_res_t typed_res);
    int         gap;
    frame_res_t want;
    gap = 0;
    cfg_if.valid <= 1'b0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid    <= 1'b1;
    in_if.target_x <= tx;
    in_if.target_y <= ty;
    do @(posedge clk); while (!in_if.ready);
    want = next_frame(tx, ty);
    if (typed) want = typed_res;
    pending_frames.push_back(want);
    n_targets++;
  endtask

  task automatic setup_axis(input int ax, input int p);
    logic [31:0] vw, fr, lo, hi;
    longint      v, c, w, lo_v, hi_v;
    case ($urandom_range(9))
      0:       vw = 32'd1;
      1:       vw = 32'h7FFF_FFFF;
      2:       vw = 32'd0;
      default: vw = $urandom_range(1, 32'h00FF_FFFF);
    endcase
    case ($urandom_range(9))
      0:       fr = 32'd0;
      1:       fr = 32'd65536;
      2:       fr = $urandom_range(65537, 131071);
      default: fr = $urandom_range(0, 65536);
    endcase
    if (p == 1) begin
      vw = 32'h7FFF_FFFF;
      fr = 32'd65536;
    end else if (p == 3) begin
      vw = 32'd1;
      fr = 32'd0;
    end
    vw[31]    = 1'($urandom_range(1));
    fr[31:17] = 15'($urandom);
    v    = longint'(vw[30:0]);
    c    = longint'($urandom_range(0, 32'h01FF_FFFF)) - 64'sd16777216;
    w    = (v == 0) ? 0 : longint'($urandom) % v;
    lo_v = POS_MIN;
    hi_v = POS_MAX;
    case ($urandom_range(9))
      3: lo_v = longint'($signed($urandom));
      4: hi_v = longint'($signed($urandom));
      5: begin
        lo_v = c - w / 2;
        hi_v = lo_v + w;
      end
      6: begin
        lo_v = c + w + 1;
        hi_v = c;
      end
      7: begin
        lo_v = POS_MIN + 1;
        hi_v = POS_MAX - 1;
      end
      8, 9: begin
        lo_v = c - longint'($urandom_range(0, 32'h00FF_FFFF));
        hi_v = lo_v + v + longint'($urandom_range(0, 32'h00FF_FFFF));
      end
      default: ;
    endcase
    lo = 32'(clamp_pos(lo_v));
    hi = 32'(clamp_pos(hi_v));
    write_reg((ax == 0) ? REG_VIEW_WIDTH : REG_VIEW_HEIGHT, vw);
    write_reg((ax == 0) ? REG_ZONE_FRAC_X : REG_ZONE_FRAC_Y, fr);
    write_reg((ax == 0) ? REG_BOUND_MIN_X : REG_BOUND_MIN_Y, lo);
    write_reg((ax == 0) ? REG_BOUND_MAX_X : REG_BOUND_MAX_Y, hi);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
    end
  endtask

  // Result side: check each beat, then decide ready for the next edge.
  initial begin
    int         hold_left;
    frame_res_t got, want;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) begin
        got = '{out_if.center_x, out_if.center_y, out_if.ratio_x, out_if.ratio_y,
                out_if.zone_width, out_if.zone_height};
        if (pending_frames.size() == 0) begin
          errors++;
          $display("%0t: result beat with nothing expected, actual %h", $time, got);
        end else begin
          want = pending_frames.pop_front();
          check_field("center_x", want.center_x, got.center_x);
          check_field("center_y", want.center_y, got.center_y);
          check_field("ratio_x", want.ratio_x, got.ratio_x);
          check_field("ratio_y", want.ratio_y, got.ratio_y);
          check_field("zone_width", 32'(want.zone_width), 32'(got.zone_width));
          check_field("zone_height", 32'(want.zone_height), 32'(got.zone_height));
          n_checked++;
        end
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready)) quiet = 0;
      else quiet++;
    end
    $display("%0t: no beat for %0d cycles", $time, QUIET_LIMIT);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    logic [31:0] tx, ty;
    errors        = 0;
    n_targets     = 0;
    n_writes      = 0;
    n_checked     = 0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_req      = 1'b0;
    for (int a = 0; a < 2; a++) begin
      axis_cfg[a].frac = longint'(ZONE_FRAC_RST);
      axis_cfg[a].bmin = POS_MIN;
      axis_cfg[a].bmax = POS_MAX;
      cam_pos[a]       = 0;
    end
    axis_cfg[0].view = longint'(VIEW_WIDTH_RST);
    axis_cfg[1].view = longint'(VIEW_HEIGHT_RST);
    rst_n           <= 1'b0;
    in_if.valid     <= 1'b0;
    in_if.target_x  <= '0;
    in_if.target_y  <= '0;
    cfg_if.valid    <= 1'b0;
    cfg_if.addr     <= '0;
    cfg_if.data     <= '0;
    out_if.ready    <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIR; i++) begin
      if (DIR_TAB[i].is_cfg) begin
        wait_idle();
        write_reg(DIR_TAB[i].idx, DIR_TAB[i].a);
      end else begin
        send_target(DIR_TAB[i].a, DIR_TAB[i].b, DIR_TAB[i].typed, DIR_TAB[i].res);
      end
    end

    for (int p = 0; p < N_PHASES; p++) begin
      wait_idle();
      setup_axis(0, p);
      setup_axis(1, p);
      case (p % 4)
        0: begin
          send_idle_pct = 0;
          stall_pct     = 0;
        end
        1: begin
          send_idle_pct = 55;
          stall_pct     = 0;
        end
        2: begin
          send_idle_pct = 0;
          stall_pct     = 55;
        end
        default: begin
          send_idle_pct = 26;
          stall_pct     = 26;
        end
      endcase
      if (p == 4) hold_req = 1'b1;
      repeat (PHASE_ITEMS) begin
        tx = pick_coord(0);
        ty = pick_coord(1);
        send_target(tx, ty, 1'b0, NO_RES);
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d target beats and %0d register writes; checked %0d result beats.",
             n_targets, n_writes, n_checked);
    $display("Covered %0d register settings, four idling mixes and a long result hold-off.",
             N_PHASES);
    if (errors == 0 && pending_frames.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+rtl
rtl/dzcf_pkg.sv
rtl/dzcf_in_if.sv
rtl/dzcf_out_if.sv
rtl/dzcf_cfg_if.sv
rtl/dzcf_div.sv
rtl/dead_zone_camera_follow_top.sv
rtl/dzcf_checker.sv
sim/dead_zone_camera_follow_top_tb.sv
